>>> rtl/cpbp_pkg.sv
// ----------------------------------------------------------------------------
// cpbp_pkg
// Shared types, codes and helpers of the control packet byte parser.
// ----------------------------------------------------------------------------
`default_nettype none

package cpbp_pkg;

  localparam int DATA_W  = 8;
  localparam int KIND_W  = 3;
  localparam int JOY_W   = 3;
  localparam int ELEM_W  = 6;
  localparam int VALUE_W = 32;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_SEQUENCE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MODE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STATION  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_AXIS     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BUTTONS  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_POV      = 3'd6;

  // Robot mode codes
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_TELEOP   = 2'd1;
  localparam logic [1:0] MODE_AUTO     = 2'd2;
  localparam logic [1:0] MODE_TEST     = 2'd3;

  // Stop request values
  localparam logic [VALUE_W-1:0] STOP_RESTART = 32'd0;
  localparam logic [VALUE_W-1:0] STOP_ESTOP   = 32'd1;

  localparam logic [DATA_W-1:0] JOY_TAG   = 8'h0c;
  localparam logic [7:0]        MASK_KEEP = 8'd4;   // mask bytes kept
  localparam logic [7:0]        BTN_CAP   = 8'd32;  // reported button count cap

  typedef enum logic [3:0] {
    PH_SEQ_HI     = 4'd0,
    PH_SEQ_LO     = 4'd1,
    PH_VERSION    = 4'd2,
    PH_CONTROL    = 4'd3,
    PH_REQUEST    = 4'd4,
    PH_STATION    = 4'd5,
    PH_REC_SIZE   = 4'd6,
    PH_TAG        = 4'd7,
    PH_AXIS_COUNT = 4'd8,
    PH_AXIS       = 4'd9,
    PH_BTN_COUNT  = 4'd10,
    PH_BTN_MASK   = 4'd11,
    PH_POV_COUNT  = 4'd12,
    PH_POV        = 4'd13,
    PH_PAD        = 4'd14,
    PH_IDLE       = 4'd15
  } phase_t;

  typedef struct packed {
    logic [KIND_W-1:0]  field_kind;
    logic [JOY_W-1:0]   joystick_number;
    logic [ELEM_W-1:0]  element_number;
    logic [VALUE_W-1:0] field_value;
  } payload_t;

  typedef struct packed {
    logic     valid;
    payload_t data;
  } result_t;

  // Alliance station: b mod 3 plus 1, by folding base-4 digits (4 = 1 mod 3).
  function automatic logic [1:0] station_of(logic [7:0] b);
    logic [3:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = 4'(b[7:6]) + 4'(b[5:4]) + 4'(b[3:2]) + 4'(b[1:0]);
    t = 3'(s[3:2]) + 3'(s[1:0]);
    u = 3'(t[2]) + 3'(t[1:0]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0] + 2'd1;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cpbp_in_if.sv
// ----------------------------------------------------------------------------
// cpbp_in_if
// Byte channel into the parser: one datagram byte and its last-byte flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpbp_in_if;
  logic                         valid;
  logic                         ready;
  logic [cpbp_pkg::DATA_W-1:0]  data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/cpbp_out_if.sv
// ----------------------------------------------------------------------------
// cpbp_out_if
// Result channel out of the parser: one decoded field per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpbp_out_if;
  logic                          valid;
  logic                          ready;
  logic [cpbp_pkg::KIND_W-1:0]   field_kind;
  logic [cpbp_pkg::JOY_W-1:0]    joystick_number;
  logic [cpbp_pkg::ELEM_W-1:0]   element_number;
  logic [cpbp_pkg::VALUE_W-1:0]  field_value;

  modport source (output valid, output field_kind, output joystick_number,
                  output element_number, output field_value, input ready);
  modport sink   (input valid, input field_kind, input joystick_number,
                  input element_number, input field_value, output ready);
endinterface

`default_nettype wire

>>> rtl/cpbp_decoder.sv
// ----------------------------------------------------------------------------
// cpbp_decoder
// Parse state registers and the per-byte decode; forms at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module cpbp_decoder #(
  parameter int MAX_JOYSTICKS = 6,
  parameter int MAX_AXES      = 16,
  parameter int MAX_POVS      = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [cpbp_pkg::DATA_W-1:0]  data_byte,
  input  wire logic                         last_byte,
  output cpbp_pkg::result_t                 res
);

  localparam int JW       = $clog2(MAX_JOYSTICKS + 1);
  localparam int JOY_OUT  = cpbp_pkg::JOY_W;
  localparam int VAL_W    = cpbp_pkg::VALUE_W;

  cpbp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       rec_left_r, rec_left_nxt;
  logic [JW-1:0]    joy_r, joy_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [7:0]       elem_r, elem_nxt;
  logic [7:0]       btn_cnt_r, btn_cnt_nxt;
  logic [31:0]      mask_r, mask_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             estop_r, estop_nxt;   // control bit 7 of this packet
  logic             pov_hi_done_r, pov_hi_done_nxt;

  logic             in_record;
  logic             joy_ok;
  logic [1:0]       mode_code;
  logic [8:0]       btn_sum;
  logic [7:0]       cnt_dec;

  assign joy_ok  = joy_r < JW'(MAX_JOYSTICKS);
  assign btn_sum = {1'b0, data_byte} + 9'd7;
  assign cnt_dec = cnt_r - 8'd1;

  always_comb begin
    phase_nxt       = phase_r;
    rec_left_nxt    = rec_left_r;
    joy_nxt         = joy_r;
    cnt_nxt         = cnt_r;
    elem_nxt        = elem_r;
    btn_cnt_nxt     = btn_cnt_r;
    mask_nxt        = mask_r;
    held_nxt        = held_r;
    estop_nxt       = estop_r;
    pov_hi_done_nxt = pov_hi_done_r;
    mode_code       = cpbp_pkg::MODE_DISABLED;
    res             = '0;

    in_record = (phase_r >= cpbp_pkg::PH_TAG) && (phase_r <= cpbp_pkg::PH_PAD);
    if (in_record) begin
      rec_left_nxt = rec_left_r - 8'd1;
    end

    unique case (phase_r)
      cpbp_pkg::PH_SEQ_HI: begin
        held_nxt  = data_byte;
        phase_nxt = cpbp_pkg::PH_SEQ_LO;
      end
      cpbp_pkg::PH_SEQ_LO: begin
        res.valid            = 1'b1;
        res.data.field_kind  = cpbp_pkg::KIND_SEQUENCE;
        res.data.field_value = {16'd0, held_r, data_byte};
        phase_nxt            = cpbp_pkg::PH_VERSION;
      end
      cpbp_pkg::PH_VERSION: begin
        phase_nxt = (data_byte != 8'd0) ? cpbp_pkg::PH_CONTROL : cpbp_pkg::PH_IDLE;
      end
      cpbp_pkg::PH_CONTROL: begin
        estop_nxt = data_byte[7];
        if (data_byte[2]) begin
          priority if (data_byte[0]) begin
            mode_code = cpbp_pkg::MODE_TEST;
          end else if (data_byte[1]) begin
            mode_code = cpbp_pkg::MODE_AUTO;
          end else begin
            mode_code = cpbp_pkg::MODE_TELEOP;
          end
        end
        res.valid            = 1'b1;
        res.data.field_kind  = cpbp_pkg::KIND_MODE;
        res.data.field_value = {29'd0, data_byte[3], mode_code};
        phase_nxt            = cpbp_pkg::PH_REQUEST;
      end
      cpbp_pkg::PH_REQUEST: begin
        priority if (data_byte[3] || data_byte[2]) begin
          res.valid            = 1'b1;
          res.data.field_kind  = cpbp_pkg::KIND_STOP;
          res.data.field_value = cpbp_pkg::STOP_RESTART;
          phase_nxt            = cpbp_pkg::PH_IDLE;
        end else if (estop_r) begin
          res.valid            = 1'b1;
          res.data.field_kind  = cpbp_pkg::KIND_STOP;
          res.data.field_value = cpbp_pkg::STOP_ESTOP;
          phase_nxt            = cpbp_pkg::PH_IDLE;
        end else begin
          phase_nxt = cpbp_pkg::PH_STATION;
        end
      end
      cpbp_pkg::PH_STATION: begin
        res.valid            = 1'b1;
        res.data.field_kind  = cpbp_pkg::KIND_STATION;
        res.data.field_value = VAL_W'(cpbp_pkg::station_of(data_byte));
        phase_nxt            = cpbp_pkg::PH_REC_SIZE;
      end
      cpbp_pkg::PH_REC_SIZE: begin
        if (data_byte == 8'd0) begin
          phase_nxt = cpbp_pkg::PH_IDLE;
        end else begin
          rec_left_nxt = data_byte;
          phase_nxt    = cpbp_pkg::PH_TAG;
        end
      end
      cpbp_pkg::PH_TAG: begin
        phase_nxt = (data_byte == cpbp_pkg::JOY_TAG) ? cpbp_pkg::PH_AXIS_COUNT
                                                      : cpbp_pkg::PH_IDLE;
      end
      cpbp_pkg::PH_AXIS_COUNT: begin
        cnt_nxt   = data_byte;
        elem_nxt  = 8'd0;
        phase_nxt = (data_byte != 8'd0) ? cpbp_pkg::PH_AXIS : cpbp_pkg::PH_BTN_COUNT;
      end
      cpbp_pkg::PH_AXIS: begin
        if (joy_ok && (elem_r < 8'(MAX_AXES))) begin
          res.valid                = 1'b1;
          res.data.field_kind      = cpbp_pkg::KIND_AXIS;
          res.data.joystick_number = JOY_OUT'(joy_r);
          res.data.element_number  = elem_r[5:0];
          res.data.field_value     = {24'd0, data_byte};
        end
        elem_nxt = elem_r + 8'd1;
        cnt_nxt  = cnt_dec;
        if (cnt_dec == 8'd0) begin
          phase_nxt = cpbp_pkg::PH_BTN_COUNT;
        end
      end
      cpbp_pkg::PH_BTN_COUNT: begin
        btn_cnt_nxt = data_byte;
        mask_nxt    = 32'd0;
        elem_nxt    = 8'd0;
        cnt_nxt     = {2'b00, btn_sum[8:3]};
        if (btn_sum[8:3] == 6'd0) begin
          if (joy_ok) begin
            res.valid                = 1'b1;
            res.data.field_kind      = cpbp_pkg::KIND_BUTTONS;
            res.data.joystick_number = JOY_OUT'(joy_r);
          end
          phase_nxt = cpbp_pkg::PH_POV_COUNT;
        end else begin
          phase_nxt = cpbp_pkg::PH_BTN_MASK;
        end
      end
      cpbp_pkg::PH_BTN_MASK: begin
        if (elem_r < cpbp_pkg::MASK_KEEP) begin
          mask_nxt = {mask_r[23:0], data_byte};
        end
        elem_nxt = elem_r + 8'd1;
        cnt_nxt  = cnt_dec;
        if (cnt_dec == 8'd0) begin
          if (joy_ok) begin
            res.valid                = 1'b1;
            res.data.field_kind      = cpbp_pkg::KIND_BUTTONS;
            res.data.joystick_number = JOY_OUT'(joy_r);
            res.data.element_number  = (btn_cnt_r > cpbp_pkg::BTN_CAP)
                                       ? cpbp_pkg::BTN_CAP[5:0] : btn_cnt_r[5:0];
            res.data.field_value     = mask_nxt;
          end
          phase_nxt = cpbp_pkg::PH_POV_COUNT;
        end
      end
      cpbp_pkg::PH_POV_COUNT: begin
        cnt_nxt         = data_byte;
        elem_nxt        = 8'd0;
        pov_hi_done_nxt = 1'b0;
        phase_nxt = (data_byte != 8'd0) ? cpbp_pkg::PH_POV : cpbp_pkg::PH_PAD;
      end
      cpbp_pkg::PH_POV: begin
        if (!pov_hi_done_r) begin
          held_nxt        = data_byte;
          pov_hi_done_nxt = 1'b1;
        end else begin
          pov_hi_done_nxt = 1'b0;
          if (joy_ok && (elem_r < 8'(MAX_POVS))) begin
            res.valid                = 1'b1;
            res.data.field_kind      = cpbp_pkg::KIND_POV;
            res.data.joystick_number = JOY_OUT'(joy_r);
            res.data.element_number  = elem_r[5:0];
            res.data.field_value     = {16'd0, held_r, data_byte};
          end
          elem_nxt = elem_r + 8'd1;
          cnt_nxt  = cnt_dec;
          if (cnt_dec == 8'd0) begin
            phase_nxt = cpbp_pkg::PH_PAD;
          end
        end
      end
      cpbp_pkg::PH_PAD, cpbp_pkg::PH_IDLE: begin
      end
      default: begin
      end
    endcase

    // record used up: step to the next record's size byte
    if (in_record && (phase_nxt != cpbp_pkg::PH_IDLE) && (rec_left_nxt == 8'd0)) begin
      if (joy_ok) begin
        joy_nxt = joy_r + JW'(1);
      end
      phase_nxt = cpbp_pkg::PH_REC_SIZE;
    end

    if (last_byte) begin
      phase_nxt       = cpbp_pkg::PH_SEQ_HI;
      rec_left_nxt    = 8'd0;
      joy_nxt         = '0;
      cnt_nxt         = 8'd0;
      elem_nxt        = 8'd0;
      btn_cnt_nxt     = 8'd0;
      estop_nxt       = 1'b0;
      pov_hi_done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= cpbp_pkg::PH_SEQ_HI;
      rec_left_r    <= 8'd0;
      joy_r         <= '0;
      cnt_r         <= 8'd0;
      elem_r        <= 8'd0;
      btn_cnt_r     <= 8'd0;
      estop_r       <= 1'b0;
      pov_hi_done_r <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      rec_left_r    <= rec_left_nxt;
      joy_r         <= joy_nxt;
      cnt_r         <= cnt_nxt;
      elem_r        <= elem_nxt;
      btn_cnt_r     <= btn_cnt_nxt;
      estop_r       <= estop_nxt;
      pov_hi_done_r <= pov_hi_done_nxt;
    end
  end

  // held byte and mask are always written before they are read
  always_ff @(posedge clk) begin
    if (accept) begin
      mask_r <= mask_nxt;
      held_r <= held_nxt;
    end
  end

`ifndef SYNTHESIS
  a_joy_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    joy_r <= JW'(MAX_JOYSTICKS))
    else $error("joystick index ran past its limit");

  a_joy_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && (res.data.field_kind == cpbp_pkg::KIND_AXIS ||
                   res.data.field_kind == cpbp_pkg::KIND_BUTTONS ||
                   res.data.field_kind == cpbp_pkg::KIND_POV))
    |-> joy_r < JW'(MAX_JOYSTICKS))
    else $error("joystick result beyond joystick limit");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_byte) |=> phase_r == cpbp_pkg::PH_SEQ_HI)
    else $error("parser did not restart after last byte");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cpbp_pkg::PH_AXIS || phase_r == cpbp_pkg::PH_BTN_MASK ||
     phase_r == cpbp_pkg::PH_POV) |-> cnt_r != 8'd0)
    else $error("field count empty inside a field list");
`endif

endmodule

`default_nettype wire

>>> rtl/cpbp_out_buf.sv
// ----------------------------------------------------------------------------
// cpbp_out_buf
// Two-entry result buffer; registers results and decouples receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cpbp_out_buf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire cpbp_pkg::payload_t push_data,
  output logic                    not_full,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output cpbp_pkg::payload_t      pop_data
);

  cpbp_pkg::payload_t mem_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  logic               pop;

  assign not_full  = count_r != 2'd2;
  assign pop_valid = count_r != 2'd0;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/control_packet_byte_parser.sv
// ----------------------------------------------------------------------------
// control_packet_byte_parser
// Byte-wise decoder of control datagrams into sequence, mode, stop, station,
// axis, button and POV fields.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one datagram byte per transaction, last_byte set on the final one.
//   out_if : at most one decoded field per input byte, in byte order.
//   in_if.ready stays high at a sustained rate of one byte per clock as long
//   as out_if is drained.
//   A field is registered into a two-entry result buffer when the byte that
//   completes it is taken, and is offered on out_if from there.
//   When the receiver stalls, the buffer holds up to two pending fields and
//   bytes that produce no field keep flowing; in_if.ready drops only while
//   the buffer is full.
//   Reset (rst_n low, synchronous) empties the buffer and leaves the parser
//   waiting for the first header byte; a byte flagged last_byte does the same
//   for the parse state after it is decoded.
//   Records past MAX_JOYSTICKS, axes past MAX_AXES and POVs past MAX_POVS are
//   parsed and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module control_packet_byte_parser #(
  parameter int MAX_JOYSTICKS = 6,
  parameter int MAX_AXES      = 16,
  parameter int MAX_POVS      = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cpbp_in_if.sink    in_if,
  cpbp_out_if.source out_if
);

  cpbp_pkg::result_t  res;
  cpbp_pkg::payload_t out_data;
  logic               accept;
  logic               buf_not_full;

  assign in_if.ready = buf_not_full;
  assign accept      = in_if.valid && buf_not_full;

  cpbp_decoder #(
    .MAX_JOYSTICKS (MAX_JOYSTICKS),
    .MAX_AXES      (MAX_AXES),
    .MAX_POVS      (MAX_POVS)
  ) u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_if.data_byte),
    .last_byte (in_if.last_byte),
    .res       (res)
  );

  cpbp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && res.valid),
    .push_data (res.data),
    .not_full  (buf_not_full),
    .pop_valid (out_if.valid),
    .pop_ready (out_if.ready),
    .pop_data  (out_data)
  );

  assign out_if.field_kind      = out_data.field_kind;
  assign out_if.joystick_number = out_data.joystick_number;
  assign out_if.element_number  = out_data.element_number;
  assign out_if.field_value     = out_data.field_value;

endmodule

`default_nettype wire
